FILE: rtl/lr_pkg.sv
// lr_pkg: shared widths, codes, reset values and types of the line rasterizer
// used by lr_if.sv, lr_walker.sv and line_rasterizer_core.sv
package lr_pkg;

  localparam int COORD_BITS   = 12;
  localparam int IN_BITS      = COORD_BITS + 1;
  localparam int ERR_BITS     = COORD_BITS + 3;
  localparam int REG_BITS     = 13;
  localparam int ADDR_BITS    = 24;
  localparam int CFG_IDX_BITS = 2;
  localparam int CMP_BITS     = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
  localparam int PROD_BITS    = REG_BITS + COORD_BITS + 1;

  localparam logic [REG_BITS-1:0] H_RES_RST     = REG_BITS'(1024);
  localparam logic [REG_BITS-1:0] V_RES_RST     = REG_BITS'(768);
  localparam logic [REG_BITS-1:0] ROW_PITCH_RST = REG_BITS'(1024);

  typedef logic [COORD_BITS-1:0]     coord_t;
  typedef logic signed [IN_BITS-1:0] pos_t;
  typedef logic signed [ERR_BITS-1:0] err_t;
  typedef logic [REG_BITS-1:0]       reg_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_H_RES     = 2'd0,
    REG_V_RES     = 2'd1,
    REG_ROW_PITCH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    opcode_t opcode;
    pos_t    start_x;
    pos_t    start_y;
    pos_t    end_x;
    pos_t    end_y;
  } cmd_t;

  typedef struct packed {
    reg_t width;
    reg_t height;
  } screen_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
    logic   last;
  } pixel_t;

endpackage

FILE: rtl/lr_if.sv
// lr_if: valid/ready channel interfaces of the line rasterizer
// command beats, pixel beats and configuration writes; widths from lr_pkg
interface lr_cmd_if;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  lr_pkg::pos_t         start_x;
  lr_pkg::pos_t         start_y;
  lr_pkg::pos_t         end_x;
  lr_pkg::pos_t         end_y;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_pix_if;
  logic                         valid;
  logic                         ready;
  lr_pkg::coord_t               pixel_x;
  lr_pkg::coord_t               pixel_y;
  logic [lr_pkg::ADDR_BITS-1:0] pixel_address;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_address, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, last_pixel, output ready);
endinterface

interface lr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lr_pkg::CFG_IDX_BITS-1:0] index;
  lr_pkg::reg_t                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/lr_walker.sv
// lr_walker: bresenham line state and the per-beat step (start or advance)
// depends on lr_pkg; result is combinational, state updates when take is high
module lr_walker (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  lr_pkg::cmd_t    cmd,
  input  lr_pkg::screen_t screen,
  output logic            res_valid,
  output lr_pkg::pixel_t  res
);

  lr_pkg::coord_t cur_col, cur_col_next;
  lr_pkg::coord_t cur_row, cur_row_next;
  lr_pkg::coord_t last_col, last_col_next;
  lr_pkg::coord_t last_row, last_row_next;
  lr_pkg::err_t   error_term, error_term_next;
  lr_pkg::coord_t major_delta, major_delta_next;
  lr_pkg::coord_t minor_delta, minor_delta_next;
  logic           row_goes_down, row_goes_down_next;
  logic           y_major, y_major_next;
  logic           line_active, line_active_next;

  // start path
  logic           swap;
  lr_pkg::pos_t   x0, y0, x1, y1;
  logic           on0, on1;
  lr_pkg::coord_t dx, ady;
  lr_pkg::pos_t   dy, dy_neg;
  logic           s_ymaj, s_down, s_zero;
  lr_pkg::coord_t s_maj, s_min;
  lr_pkg::err_t   s_err;

  // advance path
  logic           step;
  lr_pkg::coord_t row_inc;
  lr_pkg::coord_t a_col, a_row;
  lr_pkg::err_t   a_err;
  logic           reached;

  always_comb begin
    swap = cmd.end_x < cmd.start_x;
    x0   = swap ? cmd.end_x   : cmd.start_x;
    y0   = swap ? cmd.end_y   : cmd.start_y;
    x1   = swap ? cmd.start_x : cmd.end_x;
    y1   = swap ? cmd.start_y : cmd.end_y;
    on0  = !x0[lr_pkg::IN_BITS-1] && !y0[lr_pkg::IN_BITS-1] &&
           (lr_pkg::CMP_BITS'(x0[lr_pkg::COORD_BITS-1:0]) < lr_pkg::CMP_BITS'(screen.width)) &&
           (lr_pkg::CMP_BITS'(y0[lr_pkg::COORD_BITS-1:0]) < lr_pkg::CMP_BITS'(screen.height));
    on1  = !x1[lr_pkg::IN_BITS-1] && !y1[lr_pkg::IN_BITS-1] &&
           (lr_pkg::CMP_BITS'(x1[lr_pkg::COORD_BITS-1:0]) < lr_pkg::CMP_BITS'(screen.width)) &&
           (lr_pkg::CMP_BITS'(y1[lr_pkg::COORD_BITS-1:0]) < lr_pkg::CMP_BITS'(screen.height));
    dx     = x1[lr_pkg::COORD_BITS-1:0] - x0[lr_pkg::COORD_BITS-1:0];
    dy     = y1 - y0;
    dy_neg = -dy;
    ady    = dy[lr_pkg::IN_BITS-1] ? dy_neg[lr_pkg::COORD_BITS-1:0]
                                   : dy[lr_pkg::COORD_BITS-1:0];
    s_ymaj = !(dx > ady);
    s_down = dy[lr_pkg::IN_BITS-1] || (dy == '0);
    s_zero = (dx == '0) && (dy == '0);
    s_maj  = s_ymaj ? ady : dx;
    s_min  = s_ymaj ? dx  : ady;
    s_err  = $signed({2'b00, s_min, 1'b0}) - $signed({3'b000, s_maj});

    step    = !error_term[lr_pkg::ERR_BITS-1] && (error_term != '0);
    row_inc = row_goes_down ? cur_row - 1'b1 : cur_row + 1'b1;
    a_col   = (!y_major || step) ? cur_col + 1'b1 : cur_col;
    a_row   = (y_major || step) ? row_inc : cur_row;
    a_err   = error_term - (step ? $signed({2'b00, major_delta, 1'b0}) : '0)
              + $signed({2'b00, minor_delta, 1'b0});
    reached = y_major ? (a_row == last_row) : (a_col == last_col);

    cur_col_next       = cur_col;
    cur_row_next       = cur_row;
    last_col_next      = last_col;
    last_row_next      = last_row;
    error_term_next    = error_term;
    major_delta_next   = major_delta;
    minor_delta_next   = minor_delta;
    row_goes_down_next = row_goes_down;
    y_major_next       = y_major;
    line_active_next   = line_active;
    res_valid          = 1'b0;
    res                = '{col: cur_col, row: cur_row, last: 1'b0};

    unique case (cmd.opcode)
      lr_pkg::OP_START: begin
        line_active_next = 1'b0;
        if (on0 && on1) begin
          cur_col_next       = x0[lr_pkg::COORD_BITS-1:0];
          cur_row_next       = y0[lr_pkg::COORD_BITS-1:0];
          last_col_next      = x1[lr_pkg::COORD_BITS-1:0];
          last_row_next      = y1[lr_pkg::COORD_BITS-1:0];
          error_term_next    = s_err;
          major_delta_next   = s_maj;
          minor_delta_next   = s_min;
          row_goes_down_next = s_down;
          y_major_next       = s_ymaj;
          line_active_next   = !s_zero;
          res_valid          = 1'b1;
          res = '{col: x0[lr_pkg::COORD_BITS-1:0], row: y0[lr_pkg::COORD_BITS-1:0],
                  last: s_zero};
        end
      end
      lr_pkg::OP_ADVANCE: begin
        if (line_active) begin
          error_term_next = a_err;
          res_valid       = 1'b1;
          if (reached) begin
            cur_col_next     = last_col;
            cur_row_next     = last_row;
            line_active_next = 1'b0;
            res = '{col: last_col, row: last_row, last: 1'b1};
          end else begin
            cur_col_next = a_col;
            cur_row_next = a_row;
            res = '{col: a_col, row: a_row, last: 1'b0};
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col       <= '0;
      cur_row       <= '0;
      last_col      <= '0;
      last_row      <= '0;
      error_term    <= '0;
      major_delta   <= '0;
      minor_delta   <= '0;
      row_goes_down <= 1'b0;
      y_major       <= 1'b0;
      line_active   <= 1'b0;
    end else if (take) begin
      cur_col       <= cur_col_next;
      cur_row       <= cur_row_next;
      last_col      <= last_col_next;
      last_row      <= last_row_next;
      error_term    <= error_term_next;
      major_delta   <= major_delta_next;
      minor_delta   <= minor_delta_next;
      row_goes_down <= row_goes_down_next;
      y_major       <= y_major_next;
      line_active   <= line_active_next;
    end
  end

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.last |=> !line_active)
    else $error("line still active after its last pixel");

  a_mid_keeps_line: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && !res.last |=> line_active)
    else $error("line dropped before its last pixel");

  a_idle_advance: assert property (@(posedge clk) disable iff (rst)
    take && (cmd.opcode == lr_pkg::OP_ADVANCE) && !line_active |-> !res_valid)
    else $error("pixel produced with no line in progress");

endmodule

FILE: rtl/line_rasterizer_core.sv
// line_rasterizer_core: top level, input register, pixel register, address stage
// depends on lr_pkg, lr_if.sv interfaces and lr_walker
// throughput: one command beat per cycle while the pixel side takes every beat;
// the rate is bounded by the single error update in lr_walker
// reset: rst (synchronous) empties all stages, ends any line and loads default screen config
module line_rasterizer_core (
  input  logic      clk,
  input  logic      rst,
  lr_cmd_if.sink    cmd,
  lr_pix_if.source  pix,
  lr_cfg_if.sink    cfg
);

  lr_pkg::reg_t    h_res;
  lr_pkg::reg_t    v_res;
  lr_pkg::reg_t    row_pitch;
  lr_pkg::screen_t screen;

  logic            i_valid;
  lr_pkg::cmd_t    i_cmd;
  logic            p_valid;
  lr_pkg::pixel_t  p_pix;
  logic            o_valid;
  lr_pkg::coord_t  o_x;
  lr_pkg::coord_t  o_y;
  logic [lr_pkg::ADDR_BITS-1:0] o_addr;
  logic            o_last;

  logic            adv3, adv2, take;
  logic            res_valid;
  lr_pkg::pixel_t  res;
  logic [lr_pkg::PROD_BITS-1:0] addr_full;

  assign adv3      = !o_valid || pix.ready;
  assign adv2      = !p_valid || adv3;
  assign take      = i_valid && adv2;
  assign cmd.ready = !i_valid || adv2;
  assign cfg.ready = 1'b1;
  assign screen    = '{width: h_res, height: v_res};

  assign addr_full = lr_pkg::PROD_BITS'(p_pix.col)
                   + lr_pkg::PROD_BITS'(row_pitch) * lr_pkg::PROD_BITS'(p_pix.row);

  lr_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .cmd       (i_cmd),
    .screen    (screen),
    .res_valid (res_valid),
    .res       (res)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      h_res     <= lr_pkg::H_RES_RST;
      v_res     <= lr_pkg::V_RES_RST;
      row_pitch <= lr_pkg::ROW_PITCH_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        lr_pkg::REG_H_RES:     h_res     <= cfg.data;
        lr_pkg::REG_V_RES:     v_res     <= cfg.data;
        lr_pkg::REG_ROW_PITCH: row_pitch <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (cmd.ready) i_valid <= cmd.valid;
      if (adv2)      p_valid <= take && res_valid;
      if (adv3)      o_valid <= p_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.ready) begin
      i_cmd <= '{opcode:  lr_pkg::opcode_t'(cmd.opcode),
                 start_x: cmd.start_x, start_y: cmd.start_y,
                 end_x:   cmd.end_x,   end_y:   cmd.end_y};
    end
    if (adv2) p_pix <= res;
    if (adv3) begin
      o_x    <= p_pix.col;
      o_y    <= p_pix.row;
      o_addr <= addr_full[lr_pkg::ADDR_BITS-1:0];
      o_last <= p_pix.last;
    end
  end

  assign pix.valid         = o_valid;
  assign pix.pixel_x       = o_x;
  assign pix.pixel_y       = o_y;
  assign pix.pixel_address = o_addr;
  assign pix.last_pixel    = o_last;

  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    i_valid && !adv2 |=> i_valid && $stable(i_cmd))
    else $error("stalled command beat lost or changed");

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    p_valid && !adv3 |=> p_valid && $stable(p_pix))
    else $error("stalled pixel lost or changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !pix.ready |=> o_valid && $stable({o_x, o_y, o_addr, o_last}))
    else $error("stalled output beat lost or changed");

endmodule

FILE: bench/lr_pixel_check.sv
// lr_pixel_check: watches the command, pixel and configuration channels of
// line_rasterizer_core, predicts each pixel beat and compares them in order
// depends on lr_pkg and the channel interfaces of lr_if.sv
`timescale 1ns / 1ps
module lr_pixel_check (
  input  logic clk,
  input  logic rst,
  lr_cmd_if    cmd,
  lr_pix_if    pix,
  lr_cfg_if    cfg,
  output int   fail_count,
  output int   pending,
  output int   pixels_checked
);

  typedef struct packed {
    lr_pkg::coord_t               col;
    lr_pkg::coord_t               row;
    logic [lr_pkg::ADDR_BITS-1:0] addr;
    logic                         last;
  } pixel_beat_t;

  pixel_beat_t pixel_q[$];

  lr_pkg::reg_t   width_r, height_r, pitch_r;
  lr_pkg::coord_t col, row, end_col, end_row;
  int     err, major, minor;
  bit     rows_down, y_major, drawing;

  function automatic bit on_screen(int x, int y);
    return x >= 0 && y >= 0 && x < int'(width_r) && y < int'(height_r);
  endfunction

  task automatic queue_pixel(input logic last);
    pixel_beat_t p;
    logic [31:0] a;
    a = 32'(col) + 32'(pitch_r) * 32'(row);
    p.col  = col;
    p.row  = row;
    p.addr = a[lr_pkg::ADDR_BITS-1:0];
    p.last = last;
    pixel_q.push_back(p);
  endtask

  task automatic begin_line(input lr_pkg::pos_t sx, sy, ex, ey);
    int x0, y0, x1, y1, dx, dy, ady;
    x0 = sx;
    y0 = sy;
    x1 = ex;
    y1 = ey;
    drawing = 1'b0;
    if (x1 < x0) begin
      dx = x0; x0 = x1; x1 = dx;
      dy = y0; y0 = y1; y1 = dy;
    end
    if (!on_screen(x0, y0) || !on_screen(x1, y1)) return;
    dx  = x1 - x0;
    dy  = y1 - y0;
    ady = (dy < 0) ? -dy : dy;
    col     = lr_pkg::coord_t'(x0);
    row     = lr_pkg::coord_t'(y0);
    end_col = lr_pkg::coord_t'(x1);
    end_row = lr_pkg::coord_t'(y1);
    rows_down = !(dy > 0);
    y_major   = !(dx > ady);
    major = y_major ? ady : dx;
    minor = y_major ? dx : ady;
    err   = 2 * minor - major;
    if (dx == 0 && dy == 0) begin
      queue_pixel(1'b1);
    end else begin
      drawing = 1'b1;
      queue_pixel(1'b0);
    end
  endtask

  task automatic step_line();
    if (!drawing) return;
    if (err > 0) begin
      if (y_major) col = col + 1'b1;
      else row = rows_down ? row - 1'b1 : row + 1'b1;
      err = err - 2 * major;
    end
    err = err + 2 * minor;
    if (y_major) row = rows_down ? row - 1'b1 : row + 1'b1;
    else col = col + 1'b1;
    if (y_major ? (row == end_row) : (col == end_col)) begin
      col = end_col;
      row = end_row;
      drawing = 1'b0;
      queue_pixel(1'b1);
    end else begin
      queue_pixel(1'b0);
    end
  endtask

  task automatic check_pixel();
    pixel_beat_t want;
    if (pixel_q.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected pixel beat: x=%0d y=%0d addr=0x%06h last=%0b",
                 pix.pixel_x, pix.pixel_y, pix.pixel_address, pix.last_pixel);
      fail_count++;
      return;
    end
    want = pixel_q.pop_front();
    pixels_checked++;
    if (pix.pixel_x !== want.col || pix.pixel_y !== want.row ||
        pix.pixel_address !== want.addr || pix.last_pixel !== want.last) begin
      if (fail_count < 10)
        $display("pixel %0d: want x=%0d y=%0d a=%06h l=%0b, got x=%0d y=%0d a=%06h l=%0b",
                 pixels_checked, want.col, want.row, want.addr, want.last,
                 pix.pixel_x, pix.pixel_y, pix.pixel_address, pix.last_pixel);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pixel_q.delete();
      fail_count     = 0;
      pixels_checked = 0;
      width_r   = lr_pkg::H_RES_RST;
      height_r  = lr_pkg::V_RES_RST;
      pitch_r   = lr_pkg::ROW_PITCH_RST;
      col       = '0;
      row       = '0;
      end_col   = '0;
      end_row   = '0;
      err       = 0;
      major     = 0;
      minor     = 0;
      rows_down = 1'b0;
      y_major   = 1'b0;
      drawing   = 1'b0;
    end else begin
      if (pix.valid && pix.ready) check_pixel();
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          lr_pkg::REG_H_RES:     width_r  = cfg.data;
          lr_pkg::REG_V_RES:     height_r = cfg.data;
          lr_pkg::REG_ROW_PITCH: pitch_r  = cfg.data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        if (lr_pkg::opcode_t'(cmd.opcode) == lr_pkg::OP_START)
          begin_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y);
        else
          step_line();
      end
    end
    pending = pixel_q.size();
  end

endmodule

FILE: bench/tb.sv
// tb: drives line_rasterizer_core with directed and random lines in bursts,
// stalls the pixel side, steps through screen settings and gives the verdict
// depends on lr_pkg, lr_if.sv, the core and lr_pixel_check
`timescale 1ns / 1ps
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [lr_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = lr_pkg::CFG_IDX_BITS'(3);

  typedef enum {RX_FLOW, RX_MOSTLY, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic clk;
  logic rst;

  lr_cmd_if cmd_ch();
  lr_pix_if pix_ch();
  lr_cfg_if cfg_ch();

  int fail_count, pending, pixels_checked;
  int beats_sent, line_beats, settings, burst_left, idle_cycles;
  int scr_w, scr_h;
  int rx_left = 0;
  rx_mode_t rx_mode = RX_FLOW;

  line_rasterizer_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .pix (pix_ch),
    .cfg (cfg_ch)
  );

  lr_pixel_check pixel_check (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .pix            (pix_ch),
    .cfg            (cfg_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .pixels_checked (pixels_checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(4, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FLOW:   pix_ch.ready <= 1'b1;
      RX_MOSTLY: pix_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: pix_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   pix_ch.ready <= (rx_left < 2);
    endcase
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("stalled for %0d cycles with %0d pixels outstanding", idle_cycles, pending);
        $display("[line_rasterizer_core] ERROR");
        $finish;
      end
    end
  end

  function automatic lr_pkg::pos_t any_pos();
    return lr_pkg::pos_t'($urandom);
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int span(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit visible(lr_pkg::pos_t x, lr_pkg::pos_t y);
    return int'(x) >= 0 && int'(y) >= 0 && int'(x) < scr_w && int'(y) < scr_h;
  endfunction

  task automatic send_beat(input lr_pkg::opcode_t op, input lr_pkg::pos_t sx, sy, ex, ey);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 4);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid   <= 1'b1;
    cmd_ch.opcode  <= op;
    cmd_ch.start_x <= sx;
    cmd_ch.start_y <= sy;
    cmd_ch.end_x   <= ex;
    cmd_ch.end_y   <= ey;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // cut < 0 walks the whole line, otherwise it is abandoned after cut advances if the line is longer
  task automatic draw_line(input int x0, y0, x1, y1, input int cut, input int extra);
    lr_pkg::pos_t px0, py0, px1, py1;
    int steps;
    px0 = lr_pkg::pos_t'(x0);
    py0 = lr_pkg::pos_t'(y0);
    px1 = lr_pkg::pos_t'(x1);
    py1 = lr_pkg::pos_t'(y1);
    send_beat(lr_pkg::OP_START, px0, py0, px1, py1);
    line_beats++;
    steps = 0;
    if (visible(px0, py0) && visible(px1, py1)) begin
      steps = span(int'(px0), int'(px1));
      if (span(int'(py0), int'(py1)) > steps) steps = span(int'(py0), int'(py1));
    end
    if (cut >= 0 && cut < steps) steps = cut;
    repeat (steps) begin
      send_beat(lr_pkg::OP_ADVANCE, any_pos(), any_pos(), any_pos(), any_pos());
      line_beats++;
    end
    repeat (extra) send_beat(lr_pkg::OP_ADVANCE, any_pos(), any_pos(), any_pos(), any_pos());
  endtask

  task automatic write_reg(input logic [lr_pkg::CFG_IDX_BITS-1:0] idx,
                           input lr_pkg::reg_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic set_screen(input int w, input int h, input int p, input bit stray);
    if (stray) write_reg(REG_UNUSED, lr_pkg::reg_t'($urandom));
    write_reg(lr_pkg::REG_H_RES, lr_pkg::reg_t'(w));
    write_reg(lr_pkg::REG_V_RES, lr_pkg::reg_t'(h));
    write_reg(lr_pkg::REG_ROW_PITCH, lr_pkg::reg_t'(p));
    cfg_ch.valid <= 1'b0;
    scr_w = int'(lr_pkg::reg_t'(w));
    scr_h = int'(lr_pkg::reg_t'(h));
    settings++;
  endtask

  // the core can still be mid-line on beats that give no pixel
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input int budget);
    int w, h, p, x0, y0, x1, y1, reach, off, pick, stop;
    w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4096);
    h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4096);
    p = ($urandom_range(0, 4) == 0) ? $urandom_range(4097, 8191) : $urandom_range(1, 4096);
    settle();
    set_screen(w, h, p, $urandom_range(0, 3) == 0);
    stop = line_beats + budget;
    while (line_beats < stop) begin
      pick  = $urandom_range(0, 99);
      off   = $urandom_range(0, 99);
      reach = (off < 85) ? 12 : (off < 97) ? 80 : 400;
      x0 = $urandom_range(0, w - 1);
      y0 = $urandom_range(0, h - 1);
      off = $urandom_range(0, 2 * reach);
      x1 = clip(x0 + off - reach, 0, w - 1);
      off = $urandom_range(0, 2 * reach);
      y1 = clip(y0 + off - reach, 0, h - 1);
      if ($urandom_range(0, 7) == 0) begin
        x1 = w - 1;
        x0 = clip(x0, w - 1 - reach, w - 1);
      end
      if ($urandom_range(0, 7) == 0) begin
        y1 = h - 1;
        y0 = clip(y0, h - 1 - reach, h - 1);
      end
      if ($urandom_range(0, 7) == 0) begin
        y0 = 0;
        y1 = clip(y1, 0, reach);
      end
      if (pick < 70) begin
        draw_line(x0, y0, x1, y1, -1, ($urandom_range(0, 9) == 0) ? 1 : 0);
      end else if (pick < 80) begin
        draw_line(x0, y0, x1, y1, $urandom_range(0, 3), 0);
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0: x1 = w;
          1: y0 = h;
          default: begin
            x0 = any_pos();
            y0 = any_pos();
            x1 = any_pos();
            y1 = any_pos();
          end
        endcase
        draw_line(x0, y0, x1, y1, -1, 0);
      end else begin
        send_beat(lr_pkg::opcode_t'($urandom_range(0, 1)),
                  any_pos(), any_pos(), any_pos(), any_pos());
        line_beats++;
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.opcode  = lr_pkg::OP_START;
    cmd_ch.start_x = '0;
    cmd_ch.start_y = '0;
    cmd_ch.end_x   = '0;
    cmd_ch.end_y   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = lr_pkg::REG_H_RES;
    cfg_ch.data    = '0;
    beats_sent     = 0;
    line_beats     = 0;
    settings       = 1;
    burst_left     = 0;
    scr_w          = int'(lr_pkg::H_RES_RST);
    scr_h          = int'(lr_pkg::V_RES_RST);
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // reset screen settings
    draw_line(0, 0, 0, 0, -1, 0);
    draw_line(-1, 5, 10, 5, -1, 1);
    draw_line(1023, 767, 1020, 767, -1, 1);
    draw_line(0, 768, 0, 0, -1, 0);
    draw_line(5, 2, 5, 6, -1, 0);
    draw_line(5, 4, 7, 1, -1, 0);
    draw_line(0, 10, 9, 3, 2, 0);
    draw_line(0, 0, 3, 3, -1, 0);

    settle();
    set_screen(4096, 4096, 4096, 1'b0);
    draw_line(4095, 4095, 4095, 4095, -1, 0);
    draw_line(-4096, -4096, 4095, 4095, -1, 0);
    draw_line(0, 4095, 4095, 0, 1, 0);

    // address wraps past 24 bits
    settle();
    set_screen(8191, 8191, 8191, 1'b1);
    draw_line(4095, 4095, 4095, 4095, -1, 0);
    draw_line(4094, 4095, 4095, 4093, -1, 0);

    // zero width drops everything
    settle();
    set_screen(0, 8191, 1, 1'b0);
    draw_line(0, 0, 0, 0, -1, 0);
    draw_line(0, 0, 3, 1, -1, 1);

    settle();
    set_screen(1, 1, 1, 1'b0);
    draw_line(0, 0, 0, 0, -1, 0);
    draw_line(0, 0, 1, 0, -1, 0);

    repeat (5) random_phase(200);

    settle();
    $display("%0d command beats over %0d screen settings, %0d pixels checked",
             beats_sent, settings, pixels_checked);
    if (fail_count == 0 && pending == 0)
      $display("[line_rasterizer_core] OK");
    else
      $display("[line_rasterizer_core] ERROR");
    $finish;
  end

endmodule
